>>> rtl/xtea_pkg.sv
package xtea_pkg;

   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned KEY_WORDS       = 4;
   localparam int unsigned KEY_SEL_WIDTH   = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CYCLES_DEFAULT  = 32;

   localparam logic [WORD_WIDTH-1:0] XTEA_DELTA = 32'h9E37_79B9;

   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_INDEX_ZERO  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_INDEX_ONE   = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_INDEX_TWO   = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_INDEX_THREE = 4'd3;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_array_type;

   typedef struct packed {
      logic                  valid;
      mode_type              mode;
      logic [WORD_WIDTH-1:0] first;
      logic [WORD_WIDTH-1:0] second;
   } stage_type;

   function automatic logic [WORD_WIDTH-1:0] mix(input logic [WORD_WIDTH-1:0] v);
      mix = ((v << 4) ^ (v >> 5)) + v;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] round_sum(input logic [WORD_WIDTH-1:0] steps);
      round_sum = steps * XTEA_DELTA;
   endfunction

endpackage

>>> rtl/xtea_cell.sv
module xtea_cell #(
   parameter int unsigned ROUND  = 0,
   parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  xtea_pkg::key_array_type keys,
   input  xtea_pkg::stage_type     stage_in,
   output xtea_pkg::stage_type     stage_out
);
   import xtea_pkg::*;

   localparam bit                        ODD       = (ROUND % 2) == 1;
   localparam int unsigned               ENC_STEPS = (ROUND + 1) / 2;
   localparam int unsigned               DEC_STEPS = CYCLES - ENC_STEPS;
   localparam logic [WORD_WIDTH-1:0]     ENC_SUM   = round_sum(WORD_WIDTH'(ENC_STEPS));
   localparam logic [WORD_WIDTH-1:0]     DEC_SUM   = round_sum(WORD_WIDTH'(DEC_STEPS));
   localparam logic [KEY_SEL_WIDTH-1:0]  ENC_KEY   = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
   localparam logic [KEY_SEL_WIDTH-1:0]  DEC_KEY   = ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

   logic                     valid_ff;
   logic                     valid_in;
   mode_type                 mode_ff;
   logic [WORD_WIDTH-1:0]    first_ff;
   logic [WORD_WIDTH-1:0]    second_ff;
   logic [WORD_WIDTH-1:0]    first_in;
   logic [WORD_WIDTH-1:0]    second_in;
   logic                     decrypt;
   logic                     update_first;
   logic [WORD_WIDTH-1:0]    source;
   logic [WORD_WIDTH-1:0]    target;
   logic [WORD_WIDTH-1:0]    sum;
   logic [WORD_WIDTH-1:0]    key_word;
   logic [WORD_WIDTH-1:0]    round_mix;
   logic [WORD_WIDTH-1:0]    updated;

   always_comb begin
      decrypt      = (stage_in.mode == MODE_DECRYPT);
      update_first = decrypt ? ODD : !ODD;
      source       = update_first ? stage_in.second : stage_in.first;
      target       = update_first ? stage_in.first : stage_in.second;
      sum          = decrypt ? DEC_SUM : ENC_SUM;
      key_word     = keys[decrypt ? DEC_KEY : ENC_KEY];
      round_mix    = mix(source) ^ (sum + key_word);
      updated      = decrypt ? (target - round_mix) : (target + round_mix);
      first_in     = update_first ? updated : stage_in.first;
      second_in    = update_first ? stage_in.second : updated;
      valid_in     = advance ? stage_in.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_in.valid) begin
         mode_ff   <= stage_in.mode;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign stage_out.valid  = valid_ff;
   assign stage_out.mode   = mode_ff;
   assign stage_out.first  = first_ff;
   assign stage_out.second = second_ff;

endmodule

>>> rtl/xtea_block_cipher_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_mode, req_block_first, req_block_second
// rsp_      out        rsp_valid/rsp_stall  rsp_result_first, rsp_result_second
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One block enters per cycle while req_stall is low; each of the 2*CYCLES cells does one Feistel half-round.
// A block passes through the cell chain and then the output register.
// Reset clears the key words to zero and empties the chain and the output register.
// A stalled result holds in the output register while the chain keeps moving until
// its last cell holds a finished block; only then is req_stall raised.
module xtea_block_cipher_unit #(
   parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic                                     req_mode,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]          req_block_first,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]          req_block_second,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [xtea_pkg::WORD_WIDTH-1:0]          rsp_result_first,
   output logic [xtea_pkg::WORD_WIDTH-1:0]          rsp_result_second,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [xtea_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]          csr_wdata
);
   import xtea_pkg::*;

   localparam int unsigned CELLS = 2 * CYCLES;

   key_array_type          key_ff;
   key_array_type          key_in;
   stage_type              chain [0:CELLS];
   logic                   advance;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [WORD_WIDTH-1:0]  rsp_first_ff;
   logic [WORD_WIDTH-1:0]  rsp_second_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            KEY_INDEX_ZERO:  key_in[0] = csr_wdata;
            KEY_INDEX_ONE:   key_in[1] = csr_wdata;
            KEY_INDEX_TWO:   key_in[2] = csr_wdata;
            KEY_INDEX_THREE: key_in[3] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign chain[0].valid  = req_valid;
   assign chain[0].mode   = mode_type'(req_mode);
   assign chain[0].first  = req_block_first;
   assign chain[0].second = req_block_second;

   genvar cell_idx;
   generate
      for (cell_idx = 0; cell_idx < CELLS; cell_idx++) begin : g_cell
         xtea_cell #(
            .ROUND  (cell_idx),
            .CYCLES (CYCLES)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (advance),
            .keys      (key_ff),
            .stage_in  (chain[cell_idx]),
            .stage_out (chain[cell_idx+1])
         );
      end
   endgenerate

   assign advance   = !chain[CELLS].valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign rsp_valid_in = (chain[CELLS].valid && advance) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain[CELLS].valid && advance) begin
         rsp_first_ff  <= chain[CELLS].first;
         rsp_second_ff <= chain[CELLS].second;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_first  = rsp_first_ff;
   assign rsp_result_second = rsp_second_ff;

`ifndef SYNTH
   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> chain[1].valid)
      else $error("Accepted block did not enter the first cell.");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (chain[CELLS].valid && rsp_valid_ff && rsp_stall))
      else $error("Input stalled while the chain could move.");

   a_last_cell_holds: assert property (@(posedge clock) disable iff (reset)
      (chain[CELLS].valid && !advance) |=>
         (chain[CELLS].valid && $stable(chain[CELLS].first) && $stable(chain[CELLS].second)))
      else $error("Finished block in the last cell was lost during a stall.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (chain[CELLS].valid && advance) |=>
         (rsp_valid_ff && rsp_first_ff == $past(chain[CELLS].first)))
      else $error("Output register did not take the finished block.");

   a_key_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == KEY_INDEX_ZERO) |=>
         (key_ff[0] == $past(csr_wdata)))
      else $error("Key word write did not take effect.");
`endif

endmodule
